>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Depends on nothing; every macro samples on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pab_pkg.sv
// Package for the polygon area, bounding box and support point block.
// Holds widths, register indexes, stage types and the saturating add.
// Depends on nothing.
`timescale 1ns / 1ps

package pab_pkg;

   localparam int MAX_VERTS = 64;
   localparam int CNT_W     = $clog2(MAX_VERTS + 2);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_VERTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAXV  = CNT_W'(MAX_VERTS);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   localparam int COORD_W = 16;
   localparam int PROD_W  = 2 * COORD_W;
   localparam int TERM_W  = PROD_W + 1;
   localparam int CROSS_W = 39;
   localparam int AREA_W  = 38;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y = 1'b1;

   localparam logic signed [COORD_W-1:0] DIR_X_RESET = 16'sd32767;
   localparam logic signed [COORD_W-1:0] DIR_Y_RESET = 16'sd0;

   localparam logic signed [CROSS_W-1:0] CROSS_MAX = {1'b0, {(CROSS_W-1){1'b1}}};
   localparam logic signed [CROSS_W-1:0] CROSS_MIN = {1'b1, {(CROSS_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [TERM_W-1:0]  cross_in;
      logic signed [TERM_W-1:0]  cross_close;
      logic signed [TERM_W-1:0]  dot;
      logic                      first;
      logic                      last;
      logic                      overflow;
   } pab_item_type;

   typedef struct packed {
      logic [AREA_W-1:0]         area;
      logic [COORD_W-1:0]        width;
      logic [COORD_W-1:0]        height;
      logic signed [COORD_W-1:0] support_x;
      logic signed [COORD_W-1:0] support_y;
      logic                      overflow;
   } pab_result_type;

   function automatic logic signed [CROSS_W-1:0] sat_add(
      input logic signed [CROSS_W-1:0] acc,
      input logic signed [TERM_W-1:0]  term
   );
      logic [CROSS_W:0] sum;
      sum = {acc[CROSS_W-1], acc} + {{(CROSS_W+1-TERM_W){term[TERM_W-1]}}, term};
      if (sum[CROSS_W] != sum[CROSS_W-1]) begin
         sat_add = sum[CROSS_W] ? CROSS_MIN : CROSS_MAX;
      end else begin
         sat_add = sum[CROSS_W-1:0];
      end
   endfunction

endpackage

>>> rtl/polygon_area_bounds_support.sv
// A result is built through the p1 and p2 stage registers and held in the output register.
// Throughput: one vertex beat per cycle unless a closing vertex waits on a full output register.
// Results wait in an output register while later vertices flow on until the next closing vertex.
// Reset: synchronous, clears all stage valids and polygon tracking, direction = (32767, 0).
// Top level: input tracking, product stage, output register; uses pab_pkg, pab_accum.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module polygon_area_bounds_support (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [pab_pkg::COORD_W-1:0]   req_vert_x,
   input  logic signed [pab_pkg::COORD_W-1:0]   req_vert_y,
   input  logic                                 req_last_vert,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pab_pkg::AREA_W-1:0]           rsp_area_halves,
   output logic [pab_pkg::COORD_W-1:0]          rsp_width,
   output logic [pab_pkg::COORD_W-1:0]          rsp_height,
   output logic signed [pab_pkg::COORD_W-1:0]   rsp_support_x,
   output logic signed [pab_pkg::COORD_W-1:0]   rsp_support_y,
   output logic                                 rsp_overflow,
   input  logic                                 csr_we,
   input  logic [pab_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pab_pkg::COORD_W-1:0]          csr_wdata
);

   logic signed [pab_pkg::COORD_W-1:0] dir_x_ff, dir_y_ff;

   logic                               fe_start_ff;
   logic [pab_pkg::CNT_W-1:0]          fe_count_ff, fe_count_in;
   logic signed [pab_pkg::COORD_W-1:0] fe_prev_x_ff, fe_prev_y_ff;
   logic signed [pab_pkg::COORD_W-1:0] fe_first_x_ff, fe_first_y_ff;

   logic                               p1_valid_ff;
   logic signed [pab_pkg::COORD_W-1:0] p1_x_ff, p1_y_ff, p1_prev_x_ff, p1_prev_y_ff;
   logic signed [pab_pkg::COORD_W-1:0] p1_first_x_ff, p1_first_y_ff;
   logic                               p1_first_ff, p1_last_ff, p1_overflow_ff;

   logic                               p2_valid_ff;
   pab_pkg::pab_item_type              p2_item_ff, p2_item_in;

   logic                               rsp_valid_ff;
   pab_pkg::pab_result_type            rsp_res_ff, acc_result;

   logic signed [pab_pkg::PROD_W-1:0]  prod_a, prod_b, prod_c, prod_d, prod_e, prod_f;

   logic in_go, p1_go, p1_open, p2_go, p2_open, out_free;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      p2_go     = p2_valid_ff && (!p2_item_ff.last || out_free);
      p2_open   = !p2_valid_ff || p2_go;
      p1_go     = p1_valid_ff && p2_open;
      p1_open   = !p1_valid_ff || p1_go;
      req_ready = p1_open;
      in_go     = req_valid && p1_open;
   end

   always_comb begin
      if (fe_start_ff) begin
         fe_count_in = pab_pkg::CNT_ONE;
      end else if (fe_count_ff == pab_pkg::CNT_LIMIT) begin
         fe_count_in = fe_count_ff;
      end else begin
         fe_count_in = fe_count_ff + pab_pkg::CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_x_ff <= pab_pkg::DIR_X_RESET;
         dir_y_ff <= pab_pkg::DIR_Y_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pab_pkg::CSR_DIR_X: dir_x_ff <= csr_wdata;
            pab_pkg::CSR_DIR_Y: dir_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input tracking: previous vertex, first vertex and count of the open polygon.
   always_ff @(posedge clock) begin
      if (reset) begin
         fe_start_ff <= 1'b1;
         fe_count_ff <= '0;
         p1_valid_ff <= 1'b0;
      end else begin
         if (in_go) begin
            fe_start_ff <= req_last_vert;
            fe_count_ff <= fe_count_in;
         end
         if (in_go) begin
            p1_valid_ff <= 1'b1;
         end else if (p1_go) begin
            p1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_go) begin
         fe_prev_x_ff   <= req_vert_x;
         fe_prev_y_ff   <= req_vert_y;
         if (fe_start_ff) begin
            fe_first_x_ff <= req_vert_x;
            fe_first_y_ff <= req_vert_y;
         end
         p1_x_ff        <= req_vert_x;
         p1_y_ff        <= req_vert_y;
         p1_prev_x_ff   <= fe_prev_x_ff;
         p1_prev_y_ff   <= fe_prev_y_ff;
         p1_first_x_ff  <= fe_start_ff ? req_vert_x : fe_first_x_ff;
         p1_first_y_ff  <= fe_start_ff ? req_vert_y : fe_first_y_ff;
         p1_first_ff    <= fe_start_ff;
         p1_last_ff     <= req_last_vert;
         p1_overflow_ff <= (fe_count_in > pab_pkg::CNT_MAXV);
      end
   end

   always_comb begin
      prod_a = p1_prev_x_ff * p1_y_ff;
      prod_b = p1_x_ff * p1_prev_y_ff;
      prod_c = p1_x_ff * p1_first_y_ff;
      prod_d = p1_first_x_ff * p1_y_ff;
      prod_e = dir_x_ff * p1_x_ff;
      prod_f = dir_y_ff * p1_y_ff;

      p2_item_in.x           = p1_x_ff;
      p2_item_in.y           = p1_y_ff;
      p2_item_in.cross_in    = {prod_a[pab_pkg::PROD_W-1], prod_a}
                             - {prod_b[pab_pkg::PROD_W-1], prod_b};
      p2_item_in.cross_close = {prod_c[pab_pkg::PROD_W-1], prod_c}
                             - {prod_d[pab_pkg::PROD_W-1], prod_d};
      p2_item_in.dot         = {prod_e[pab_pkg::PROD_W-1], prod_e}
                             + {prod_f[pab_pkg::PROD_W-1], prod_f};
      p2_item_in.first       = p1_first_ff;
      p2_item_in.last        = p1_last_ff;
      p2_item_in.overflow    = p1_overflow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (p1_go) begin
            p2_valid_ff <= 1'b1;
         end else if (p2_go) begin
            p2_valid_ff <= 1'b0;
         end
         if (p2_go && p2_item_ff.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p1_go) begin
         p2_item_ff <= p2_item_in;
      end
      if (p2_go && p2_item_ff.last) begin
         rsp_res_ff <= acc_result;
      end
   end

   pab_accum u_accum (
      .clock  (clock),
      .go     (p2_go),
      .item   (p2_item_ff),
      .result (acc_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_area_halves = rsp_res_ff.area;
   assign rsp_width       = rsp_res_ff.width;
   assign rsp_height      = rsp_res_ff.height;
   assign rsp_support_x   = rsp_res_ff.support_x;
   assign rsp_support_y   = rsp_res_ff.support_y;
   assign rsp_overflow    = rsp_res_ff.overflow;

   `ASSERT_CLK(a_count_bound, clock, reset, fe_count_ff <= pab_pkg::CNT_LIMIT, "vertex count past its limit")
   `ASSERT_CLK(a_first_no_overflow, clock, reset, p2_valid_ff && p2_item_ff.first |-> !p2_item_ff.overflow, "first vertex marked overflow")
   `ASSERT_CLK(a_open_polygon_count, clock, reset, in_go && !fe_start_ff |-> fe_count_ff != '0, "open polygon has no vertex")

endmodule

>>> rtl/pab_accum.sv
// Accumulator stage: shoelace sum, bounding box and support vertex per polygon.
// Builds the result of a closing vertex for the output register.
// Depends on pab_pkg.
`timescale 1ns / 1ps

module pab_accum (
   input  logic                    clock,
   input  logic                    go,
   input  pab_pkg::pab_item_type   item,
   output pab_pkg::pab_result_type result
);

   logic signed [pab_pkg::CROSS_W-1:0] cross_sum_ff, cross_sum_in;
   logic signed [pab_pkg::COORD_W-1:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [pab_pkg::COORD_W-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic signed [pab_pkg::COORD_W-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic signed [pab_pkg::TERM_W-1:0]  best_dot_ff, best_dot_in;

   logic signed [pab_pkg::CROSS_W-1:0] base_sum;
   logic [pab_pkg::CROSS_W-1:0]        magnitude;
   logic                               take_best;

   always_comb begin
      base_sum = item.first ? '0 : pab_pkg::sat_add(cross_sum_ff, item.cross_in);
      cross_sum_in = item.last ? pab_pkg::sat_add(base_sum, item.cross_close) : base_sum;

      if (item.first) begin
         min_x_in = item.x;
         max_x_in = item.x;
         min_y_in = item.y;
         max_y_in = item.y;
      end else begin
         min_x_in = ($signed(item.x) < $signed(min_x_ff)) ? item.x : min_x_ff;
         max_x_in = ($signed(item.x) > $signed(max_x_ff)) ? item.x : max_x_ff;
         min_y_in = ($signed(item.y) < $signed(min_y_ff)) ? item.y : min_y_ff;
         max_y_in = ($signed(item.y) > $signed(max_y_ff)) ? item.y : max_y_ff;
      end

      take_best   = item.first || ($signed(item.dot) > $signed(best_dot_ff));
      best_x_in   = take_best ? item.x   : best_x_ff;
      best_y_in   = take_best ? item.y   : best_y_ff;
      best_dot_in = take_best ? item.dot : best_dot_ff;

      magnitude = cross_sum_in[pab_pkg::CROSS_W-1] ? -cross_sum_in : cross_sum_in;

      result.area      = magnitude[pab_pkg::CROSS_W-1] ? {pab_pkg::AREA_W{1'b1}}
                                                       : magnitude[pab_pkg::AREA_W-1:0];
      result.width     = pab_pkg::COORD_W'(max_x_in - min_x_in);
      result.height    = pab_pkg::COORD_W'(max_y_in - min_y_in);
      result.support_x = best_x_in;
      result.support_y = best_y_in;
      result.overflow  = item.overflow;
   end

   // The first vertex of a polygon loads every field, so no clear is needed.
   always_ff @(posedge clock) begin
      if (go) begin
         cross_sum_ff <= cross_sum_in;
         min_x_ff     <= min_x_in;
         max_x_ff     <= max_x_in;
         min_y_ff     <= min_y_in;
         max_y_ff     <= max_y_in;
         best_x_ff    <= best_x_in;
         best_y_ff    <= best_y_in;
         best_dot_ff  <= best_dot_in;
      end
   end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for polygon_area_bounds_support: shoelace area, bounding box and
// support vertex per polygon, predicted in-line and compared beat by beat.
// Depends on rtl/pab_pkg.sv and rtl/polygon_area_bounds_support.sv.
`timescale 1ns / 1ps

module tb_top;
   import pab_pkg::*;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      closes;
   } vertex_type;

   typedef enum int {SHAPE_WIDE, SHAPE_LOCAL, SHAPE_TIES, SHAPE_CORNERS, SHAPE_LONG} shape_type;

   localparam logic signed [COORD_W-1:0] C_HI = 16'sh7fff;
   localparam logic signed [COORD_W-1:0] C_LO = 16'sh8000;
   localparam longint AREA_TOP = (longint'(1) << AREA_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_W-1:0] req_vert_x = '0;
   logic signed [COORD_W-1:0] req_vert_y = '0;
   logic req_last_vert = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [AREA_W-1:0] rsp_area_halves;
   logic [COORD_W-1:0] rsp_width;
   logic [COORD_W-1:0] rsp_height;
   logic signed [COORD_W-1:0] rsp_support_x;
   logic signed [COORD_W-1:0] rsp_support_y;
   logic rsp_overflow;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0] csr_wdata = '0;

   vertex_type vertex_feed[$];
   pab_result_type poly_summaries_due[$];
   int mismatch_count = 0;
   int tx_gap = 0;
   int rx_gap = 0;
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;
   bit hold_go = 1'b0;
   logic rsp_hold = 1'b0;

   logic signed [COORD_W-1:0] dir_x_m = DIR_X_RESET;
   logic signed [COORD_W-1:0] dir_y_m = DIR_Y_RESET;
   logic signed [COORD_W-1:0] ring_x0 = '0, ring_y0 = '0, tail_x = '0, tail_y = '0;
   logic signed [COORD_W-1:0] lo_x = '0, hi_x = '0, lo_y = '0, hi_y = '0;
   logic signed [COORD_W-1:0] lead_x = '0, lead_y = '0;
   logic signed [TERM_W-1:0] lead_dot = '0;
   logic signed [CROSS_W-1:0] ring_sum = '0;
   int verts_seen = 0;

   polygon_area_bounds_support dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_vert_x(req_vert_x),
      .req_vert_y(req_vert_y),
      .req_last_vert(req_last_vert),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_area_halves(rsp_area_halves),
      .rsp_width(rsp_width),
      .rsp_height(rsp_height),
      .rsp_support_x(rsp_support_x),
      .rsp_support_y(rsp_support_y),
      .rsp_overflow(rsp_overflow),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #10ms;
      $display("tb_top: done, errors");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
      end
   endtask

   function automatic int pick_gap(input bit calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [CROSS_W-1:0] clamp_ring(input longint s);
      if (s > longint'(CROSS_MAX)) return CROSS_MAX;
      if (s < longint'(CROSS_MIN)) return CROSS_MIN;
      return CROSS_W'(s);
   endfunction

   task automatic fold_vertex(input vertex_type v);
      longint dot;
      longint mag;
      pab_result_type r;
      dot = longint'(dir_x_m) * longint'(v.x) + longint'(dir_y_m) * longint'(v.y);
      if (verts_seen == 0) begin
         ring_x0 = v.x;
         ring_y0 = v.y;
         lo_x = v.x;
         hi_x = v.x;
         lo_y = v.y;
         hi_y = v.y;
         lead_x = v.x;
         lead_y = v.y;
         lead_dot = TERM_W'(dot);
         ring_sum = '0;
      end else begin
         ring_sum = clamp_ring(longint'(ring_sum) + longint'(tail_x) * longint'(v.y)
                               - longint'(v.x) * longint'(tail_y));
         if (v.x < lo_x) lo_x = v.x;
         if (v.x > hi_x) hi_x = v.x;
         if (v.y < lo_y) lo_y = v.y;
         if (v.y > hi_y) hi_y = v.y;
         if (dot > longint'(lead_dot)) begin
            lead_x = v.x;
            lead_y = v.y;
            lead_dot = TERM_W'(dot);
         end
      end
      tail_x = v.x;
      tail_y = v.y;
      if (verts_seen < MAX_VERTS + 1) verts_seen++;
      if (v.closes) begin
         ring_sum = clamp_ring(longint'(ring_sum) + longint'(v.x) * longint'(ring_y0)
                               - longint'(ring_x0) * longint'(v.y));
         mag = longint'(ring_sum);
         if (mag < 0) mag = -mag;
         if (mag > AREA_TOP) mag = AREA_TOP;
         r.area = AREA_W'(mag);
         r.width = hi_x - lo_x;
         r.height = hi_y - lo_y;
         r.support_x = lead_x;
         r.support_y = lead_y;
         r.overflow = (verts_seen > MAX_VERTS);
         poly_summaries_due.push_back(r);
         ring_x0 = '0; ring_y0 = '0; tail_x = '0; tail_y = '0;
         lo_x = '0; hi_x = '0; lo_y = '0; hi_y = '0;
         lead_x = '0; lead_y = '0; lead_dot = '0;
         ring_sum = '0;
         verts_seen = 0;
      end
   endtask

   task automatic check_summary();
      pab_result_type want;
      if (poly_summaries_due.size() == 0) begin
         flag_mismatch("beat with nothing due", 64'(rsp_area_halves), 64'(0));
         return;
      end
      want = poly_summaries_due.pop_front();
      if (rsp_area_halves !== want.area) begin
         flag_mismatch("area_halves", 64'(rsp_area_halves), 64'(want.area));
      end
      if (rsp_width !== want.width) begin
         flag_mismatch("width", 64'(rsp_width), 64'(want.width));
      end
      if (rsp_height !== want.height) begin
         flag_mismatch("height", 64'(rsp_height), 64'(want.height));
      end
      if (rsp_support_x !== want.support_x) begin
         flag_mismatch("support_x", 64'(rsp_support_x), 64'(want.support_x));
      end
      if (rsp_support_y !== want.support_y) begin
         flag_mismatch("support_y", 64'(rsp_support_y), 64'(want.support_y));
      end
      if (rsp_overflow !== want.overflow) begin
         flag_mismatch("overflow", 64'(rsp_overflow), 64'(want.overflow));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            fold_vertex('{req_vert_x, req_vert_y, req_last_vert});
         end
         if (!req_valid || req_ready) begin
            if (tx_gap > 0) begin
               tx_gap <= tx_gap - 1;
               req_valid <= 1'b0;
            end else if (vertex_feed.size() > 0) begin
               req_vert_x <= vertex_feed[0].x;
               req_vert_y <= vertex_feed[0].y;
               req_last_vert <= vertex_feed[0].closes;
               void'(vertex_feed.pop_front());
               req_valid <= 1'b1;
               tx_gap <= pick_gap(tx_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      int g;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_summary();
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            g = pick_gap(rx_calm);
            rx_gap <= g;
            rsp_ready <= (g == 0);
         end else begin
            rsp_ready <= rx_calm || ($urandom_range(0, 9) != 0);
         end
      end
   end

   // The receiver holds off long enough for the pipeline to back up into the input.
   initial begin
      while (!hold_go) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic queue_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y, input bit closes);
      vertex_feed.push_back('{x, y, closes});
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord(input shape_type shape);
      case (shape)
         SHAPE_LOCAL: return COORD_W'(int'($urandom_range(0, 4000)) - 2000);
         SHAPE_TIES: begin
            case ($urandom_range(0, 3))
               0: return -16'sd256;
               1: return 16'sd0;
               2: return 16'sd1;
               default: return 16'sd256;
            endcase
         end
         SHAPE_CORNERS: begin
            case ($urandom_range(0, 3))
               0: return C_LO;
               1: return C_HI;
               2: return 16'sd0;
               default: return -16'sd1;
            endcase
         end
         SHAPE_LONG: begin
            if ($urandom_range(0, 1)) return COORD_W'($urandom_range(0, 65535));
            return COORD_W'(int'($urandom_range(0, 1000)) - 500);
         end
         default: return COORD_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic queue_polygon(input int n, input shape_type shape, input bit closed);
      for (int i = 0; i < n; i++) begin
         queue_vertex(rand_coord(shape), rand_coord(shape), closed && (i == n - 1));
      end
   endtask

   // Going round the largest triangle many times drives the cross sum into saturation.
   task automatic queue_laps(input int laps, input bit clockwise);
      vertex_type corner[3];
      corner[0] = '{C_LO, C_LO, 1'b0};
      corner[1] = '{C_HI, C_LO, 1'b0};
      corner[2] = '{C_HI, C_HI, 1'b0};
      for (int j = 0; j < 3 * laps; j++) begin
         queue_vertex(corner[clockwise ? 2 - (j % 3) : j % 3].x,
                      corner[clockwise ? 2 - (j % 3) : j % 3].y, j == 3 * laps - 1);
      end
   endtask

   task automatic settle();
      while (vertex_feed.size() != 0 || req_valid || poly_summaries_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic write_dir(input logic [CSR_IDX_W-1:0] idx,
                            input logic signed [COORD_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DIR_X) dir_x_m = value;
      else dir_y_m = value;
   endtask

   initial begin
      int fed;
      int n;
      int roll;
      int spin;
      logic signed [COORD_W-1:0] dx;
      logic signed [COORD_W-1:0] dy;
      shape_type shape;

      while (reset) @(negedge clock);

      queue_vertex(C_HI, C_LO, 1'b1);
      queue_vertex(C_LO, C_HI, 1'b1);
      queue_vertex(16'sd0, 16'sd0, 1'b0);
      queue_vertex(16'sd256, 16'sd0, 1'b0);
      queue_vertex(16'sd256, 16'sd256, 1'b0);
      queue_vertex(16'sd0, 16'sd256, 1'b1);
      queue_vertex(C_LO, C_LO, 1'b0);
      queue_vertex(C_HI, C_LO, 1'b0);
      queue_vertex(C_HI, C_HI, 1'b1);
      queue_vertex(C_HI, C_HI, 1'b0);
      queue_vertex(C_HI, C_LO, 1'b0);
      queue_vertex(C_LO, C_LO, 1'b1);
      queue_vertex(16'sd100, 16'sd100, 1'b0);
      queue_vertex(-16'sd50, 16'sd200, 1'b0);
      settle();
      write_dir(CSR_DIR_X, '0);
      write_dir(CSR_DIR_Y, '0);
      queue_vertex(16'sd300, -16'sd300, 1'b0);
      queue_vertex(16'sd5, 16'sd5, 1'b1);
      queue_vertex(-16'sd5, 16'sd7, 1'b0);
      queue_vertex(16'sd9, 16'sd9, 1'b0);
      queue_vertex(16'sd1, -16'sd3, 1'b1);
      settle();
      write_dir(CSR_DIR_X, C_LO);
      write_dir(CSR_DIR_Y, C_LO);
      queue_vertex(C_HI, C_HI, 1'b0);
      queue_vertex(C_LO, C_LO, 1'b0);
      queue_vertex(C_LO, C_LO, 1'b1);

      for (int phase = 0; phase < 8; phase++) begin
         settle();
         case (phase)
            0: begin dx = C_HI; dy = C_HI; end
            1: begin dx = C_LO; dy = '0; end
            2: begin dx = '0; dy = C_LO; end
            3: begin dx = C_LO; dy = C_HI; end
            default: begin
               dx = COORD_W'($urandom);
               dy = COORD_W'($urandom);
            end
         endcase
         write_dir(CSR_DIR_X, dx);
         write_dir(CSR_DIR_Y, dy);
         tx_calm = (phase == 6);
         rx_calm = (phase == 6);
         if (phase == 1) queue_laps(66, 1'b0);
         if (phase == 5) queue_laps(66, 1'b1);
         if (phase == 3) hold_go = 1'b1;
         fed = 0;
         while (fed < 80) begin
            roll = $urandom_range(0, 99);
            if (phase == 3) begin
               shape = SHAPE_WIDE;
               n = $urandom_range(1, 2);
            end else if (roll < 35) begin
               shape = SHAPE_WIDE;
               n = $urandom_range(1, 4);
            end else if (roll < 60) begin
               shape = SHAPE_LOCAL;
               n = $urandom_range(3, 16);
            end else if (roll < 77) begin
               shape = SHAPE_TIES;
               n = $urandom_range(1, 6);
            end else if (roll < 94) begin
               shape = SHAPE_CORNERS;
               n = $urandom_range(1, 5);
            end else begin
               shape = SHAPE_LONG;
               n = $urandom_range(62, 67);
            end
            queue_polygon(n, shape, 1'b1);
            fed += n;
         end
         if (phase < 7 && $urandom_range(0, 1)) begin
            queue_polygon($urandom_range(1, 3), SHAPE_LOCAL, 1'b0);
         end
      end

      while (vertex_feed.size() != 0 || req_valid) @(negedge clock);
      spin = 0;
      while (poly_summaries_due.size() != 0 && spin < 4000) begin
         @(negedge clock);
         spin++;
      end
      repeat (10) @(negedge clock);
      if (poly_summaries_due.size() != 0) begin
         flag_mismatch("beats never delivered", 64'(0), 64'(poly_summaries_due.size()));
      end
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

>>> polygon_area_bounds_support.f
+incdir+rtl
rtl/pab_pkg.sv
rtl/pab_accum.sv
rtl/polygon_area_bounds_support.sv
verif/tb_top.sv
